@@ rtl/core/sbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg: shared types, codes and helpers
// Token kinds, sub codes, the result record and byte classification.
// ----------------------------------------------------------------------------
package sbt_pkg;

    // Width of the position and length counters; offsets leave as 32 bits.
    localparam int POS_BITS = 32;

    localparam logic [3:0] KIND_NUM     = 4'd0;
    localparam logic [3:0] KIND_SEMI    = 4'd1;
    localparam logic [3:0] KIND_COLON   = 4'd2;
    localparam logic [3:0] KIND_ASSIGN  = 4'd3;
    localparam logic [3:0] KIND_LCURLY  = 4'd4;
    localparam logic [3:0] KIND_RCURLY  = 4'd5;
    localparam logic [3:0] KIND_OP      = 4'd6;
    localparam logic [3:0] KIND_KEYWORD = 4'd7;
    localparam logic [3:0] KIND_IDENT   = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;
    localparam logic [3:0] KIND_ERROR   = 4'd10;

    localparam logic [2:0] SUB_NONE     = 3'd0;
    localparam logic [2:0] SUB_PLUS     = 3'd0;
    localparam logic [2:0] SUB_MINUS    = 3'd1;
    localparam logic [2:0] SUB_STAR     = 3'd2;
    localparam logic [2:0] SUB_SLASH    = 3'd3;
    localparam logic [2:0] SUB_LESS     = 3'd4;
    localparam logic [2:0] SUB_GREATER  = 3'd5;
    localparam logic [2:0] SUB_KW_RETURN = 3'd0;
    localparam logic [2:0] SUB_KW_IF     = 3'd1;
    localparam logic [2:0] SUB_KW_WHILE  = 3'd2;
    localparam logic [2:0] SUB_ERR_UNKNOWN     = 3'd0;
    localparam logic [2:0] SUB_ERR_UNSEPARATED = 3'd1;

    // First six bytes of a word, first byte highest.
    localparam logic [47:0] WORD_RETURN = 48'h72_65_74_75_72_6E;
    localparam logic [47:0] WORD_WHILE  = 48'h00_77_68_69_6C_65;
    localparam logic [47:0] WORD_IF     = 48'h00_00_00_00_69_66;
    localparam int          PREFIX_BYTES = 6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  sub;
        logic [31:0] offset;
        logic [31:0] length;
        logic [63:0] value;
        logic        last;
    } t_result;

    // Up to two results produced by one byte beat.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [3:0] kind;
        logic [2:0] sub;
    } t_punct;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic t_punct punct_decode(input logic [7:0] c);
        t_punct p;
        p = '{hit: 1'b1, kind: KIND_OP, sub: SUB_NONE};
        unique case (c)
            8'h3B: p.kind = KIND_SEMI;
            8'h3A: p.kind = KIND_COLON;
            8'h3D: p.kind = KIND_ASSIGN;
            8'h7B: p.kind = KIND_LCURLY;
            8'h7D: p.kind = KIND_RCURLY;
            8'h2B: p.sub  = SUB_PLUS;
            8'h2D: p.sub  = SUB_MINUS;
            8'h2A: p.sub  = SUB_STAR;
            8'h2F: p.sub  = SUB_SLASH;
            8'h3C: p.sub  = SUB_LESS;
            8'h3E: p.sub  = SUB_GREATER;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    // Position-width value cut or zero-extended to the 32-bit output field.
    function automatic logic [31:0] to_out32(input logic [POS_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage

@@ rtl/core/source_byte_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer: byte-stream lexer
// Turns source bytes into number, word, keyword, punctuation, end and error
// tokens with offset and length.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  -------   -----------------   ---------------------------------------------
//  in        i_valid / o_ready   i_mode, i_ch
//  out       o_valid / i_ready   o_token_kind, o_sub_code, o_token_offset,
//                                o_token_length, o_number_value, o_final_res
//
//  One byte beat is taken per cycle while the result queue has room. A beat
//  is held in the input register and scanned there; its results go to the
//  result queue. A beat that yields two results shows them one after the
//  other; the four-entry result queue and its single read port set the
//  sustained rate. Synchronous reset puts the scanner back to idle at position
//  zero. A stalled output fills the queue, after which o_ready drops.
//
module source_byte_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [2:0]  o_sub_code,
    output logic [31:0] o_token_offset,
    output logic [31:0] o_token_length,
    output logic [63:0] o_number_value,
    output logic        o_final_res
);

    sbt_pkg::t_push   push;   // results of the beat being scanned
    sbt_pkg::t_result res;    // head of the result queue
    logic             room;   // queue can take two more results

    // Scanner: input register plus lexer state (mode, position, run start,
    // decimal accumulator with saturation flag, six-byte word prefix).
    sbt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_ch    (i_ch),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue: decouples scanner from output back-pressure.
    sbt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_token_kind   = res.kind;
    assign o_sub_code     = res.sub;
    assign o_token_offset = res.offset;
    assign o_token_length = res.length;
    assign o_number_value = res.value;
    assign o_final_res    = res.last;

endmodule

@@ rtl/core/sbt_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_scan: input register and scanner state
// Holds one byte beat, classifies it against the scan state and hands up to
// two results to the output queue in the same step.
// ----------------------------------------------------------------------------
module sbt_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [7:0]         i_ch,
    input  logic               i_room,
    output sbt_pkg::t_push     o_push
);

    localparam logic [1:0] SCAN_IDLE = 2'd0;
    localparam logic [1:0] SCAN_NUM  = 2'd1;
    localparam logic [1:0] SCAN_WORD = 2'd2;
    localparam logic [1:0] SCAN_FAIL = 2'd3;

    logic                         r_in_valid;
    logic                         r_mode;
    logic [7:0]                   r_ch;

    logic [1:0]                   r_scan, n_scan;
    logic [sbt_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [sbt_pkg::POS_BITS-1:0] r_start, n_start;
    logic [63:0]                  r_acc, n_acc;
    logic                         r_sat, n_sat;
    logic [47:0]                  r_prefix, n_prefix;

    logic                         advance;
    logic [sbt_pkg::POS_BITS-1:0] run_len;
    logic [67:0]                  prod;
    logic                         c_digit, c_alpha, c_word, c_space;
    sbt_pkg::t_punct              punct;
    sbt_pkg::t_result             num_res, word_res, pre_res, post_res;
    logic                         have_pre, have_post, from_idle;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_ch   <= i_ch;
        end
    end

    assign run_len = r_pos - r_start;
    assign c_digit = sbt_pkg::is_digit(r_ch);
    assign c_alpha = sbt_pkg::is_alpha(r_ch);
    assign c_word  = c_alpha || c_digit || (r_ch == 8'h5F);
    assign c_space = sbt_pkg::is_space(r_ch);
    assign punct   = sbt_pkg::punct_decode(r_ch);

    // acc*10 + digit; any carry above bit 63 means saturation
    assign prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 68'(r_ch[3:0]);

    always_comb begin
        num_res = '{kind: sbt_pkg::KIND_NUM, sub: sbt_pkg::SUB_NONE,
                    offset: sbt_pkg::to_out32(r_start),
                    length: sbt_pkg::to_out32(run_len), value: r_acc, last: 1'b0};
        word_res = '{kind: sbt_pkg::KIND_IDENT, sub: sbt_pkg::SUB_NONE,
                     offset: sbt_pkg::to_out32(r_start),
                     length: sbt_pkg::to_out32(run_len), value: 64'd0, last: 1'b0};
        if (run_len == sbt_pkg::POS_BITS'(6) && r_prefix == sbt_pkg::WORD_RETURN) begin
            word_res.kind = sbt_pkg::KIND_KEYWORD;
            word_res.sub  = sbt_pkg::SUB_KW_RETURN;
        end else if (run_len == sbt_pkg::POS_BITS'(2) && r_prefix == sbt_pkg::WORD_IF) begin
            word_res.kind = sbt_pkg::KIND_KEYWORD;
            word_res.sub  = sbt_pkg::SUB_KW_IF;
        end else if (run_len == sbt_pkg::POS_BITS'(5) && r_prefix == sbt_pkg::WORD_WHILE) begin
            word_res.kind = sbt_pkg::KIND_KEYWORD;
            word_res.sub  = sbt_pkg::SUB_KW_WHILE;
        end
    end

    always_comb begin
        n_scan    = r_scan;
        n_pos     = r_pos + sbt_pkg::POS_BITS'(1);
        n_start   = r_start;
        n_acc     = r_acc;
        n_sat     = r_sat;
        n_prefix  = r_prefix;
        have_pre  = 1'b0;
        have_post = 1'b0;
        from_idle = 1'b0;
        pre_res   = num_res;
        post_res  = '{kind: sbt_pkg::KIND_ERROR, sub: sbt_pkg::SUB_NONE,
                      offset: sbt_pkg::to_out32(r_pos), length: 32'd0,
                      value: 64'd0, last: 1'b0};

        if (r_mode) begin
            // end of source: flush pending run, then the end token, then reset
            have_pre      = (r_scan == SCAN_NUM) || (r_scan == SCAN_WORD);
            pre_res       = (r_scan == SCAN_WORD) ? word_res : num_res;
            have_post     = 1'b1;
            post_res.kind = sbt_pkg::KIND_END;
            n_scan        = SCAN_IDLE;
            n_pos         = '0;
            n_start       = '0;
            n_acc         = '0;
            n_sat         = 1'b0;
            n_prefix      = '0;
        end else begin
            unique case (r_scan)
                SCAN_NUM: begin
                    if (c_digit) begin
                        if (!r_sat) begin
                            if (prod[67:64] != 4'd0) begin
                                n_acc = '1;
                                n_sat = 1'b1;
                            end else begin
                                n_acc = prod[63:0];
                            end
                        end
                    end else if (c_alpha) begin
                        have_post    = 1'b1;
                        post_res.sub = sbt_pkg::SUB_ERR_UNSEPARATED;
                        n_scan       = SCAN_FAIL;
                    end else begin
                        have_pre  = 1'b1;
                        pre_res   = num_res;
                        from_idle = 1'b1;
                    end
                end
                SCAN_WORD: begin
                    if (c_word) begin
                        if (run_len < sbt_pkg::POS_BITS'(sbt_pkg::PREFIX_BYTES)) begin
                            n_prefix = {r_prefix[39:0], r_ch};
                        end
                    end else begin
                        have_pre  = 1'b1;
                        pre_res   = word_res;
                        from_idle = 1'b1;
                    end
                end
                SCAN_FAIL: begin
                end
                default: begin
                    from_idle = 1'b1;
                end
            endcase

            if (from_idle) begin
                n_scan = SCAN_IDLE;
                priority if (c_space) begin
                end else if (c_digit) begin
                    n_scan  = SCAN_NUM;
                    n_start = r_pos;
                    n_acc   = 64'(r_ch[3:0]);
                    n_sat   = 1'b0;
                end else if (c_alpha || r_ch == 8'h5F) begin
                    n_scan   = SCAN_WORD;
                    n_start  = r_pos;
                    n_prefix = 48'(r_ch);
                end else if (punct.hit) begin
                    have_post       = 1'b1;
                    post_res.kind   = punct.kind;
                    post_res.sub    = punct.sub;
                    post_res.length = 32'd1;
                end else begin
                    have_post    = 1'b1;
                    post_res.sub = sbt_pkg::SUB_ERR_UNKNOWN;
                    n_scan       = SCAN_FAIL;
                end
            end
        end
    end

    always_comb begin
        o_push.count = advance ? ({1'b0, have_pre} + {1'b0, have_post}) : 2'd0;
        o_push.slot0 = have_pre ? pre_res : post_res;
        o_push.slot1 = post_res;
        o_push.slot0.last = !(have_pre && have_post);
        o_push.slot1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= SCAN_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_acc    <= '0;
            r_sat    <= 1'b0;
            r_prefix <= '0;
        end else if (advance) begin
            r_scan   <= n_scan;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_acc    <= n_acc;
            r_sat    <= n_sat;
            r_prefix <= n_prefix;
        end
    end

endmodule

@@ rtl/core/sbt_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_out_queue: four-entry result queue
// Takes up to two results per cycle, presents one result beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module sbt_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbt_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output sbt_pkg::t_result o_res
);

    sbt_pkg::t_result r_mem [4];
    logic [1:0]       r_wptr, n_wptr;
    logic [1:0]       r_rptr, n_rptr;
    logic [2:0]       r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rptr];

    assign n_wptr  = r_wptr + i_push.count;
    assign n_rptr  = r_rptr + {1'b0, pop};
    assign n_count = r_count + {1'b0, i_push.count} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for source_byte_tokenizer
// Streams source text and end beats into the lexer while an internal scanner
// model predicts every token. Each output beat is checked against the oldest
// predicted token. A short directed text comes first, then random token runs
// with noise, error runs, saturating numbers and near-miss keywords, under
// bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RADIX    = 10;
    localparam logic [63:0] U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          TARGET_BEATS = 780;
    localparam int          DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {LX_IDLE, LX_NUM, LX_WORD, LX_FAIL} t_lex_state;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } t_src_beat;

    // DUT ports; every input is known from time zero
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode  = 1'b0;
    logic [7:0]  i_ch    = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_token_kind;
    logic [2:0]  o_sub_code;
    logic [31:0] o_token_offset;
    logic [31:0] o_token_length;
    logic [63:0] o_number_value;
    logic        o_final_res;

    source_byte_tokenizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_sub_code     (o_sub_code),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_number_value (o_number_value),
        .o_final_res    (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scanner model state
    // ------------------------------------------------------------------------
    t_lex_state                   lex_state  = LX_IDLE;
    logic [sbt_pkg::POS_BITS-1:0] lex_pos    = '0;
    logic [sbt_pkg::POS_BITS-1:0] lex_start  = '0;
    logic [63:0]                  lex_acc    = '0;
    logic                         lex_sat    = 1'b0;
    logic [47:0]                  lex_prefix = '0;

    t_src_beat        source_beats[$];   // beats still to be driven
    sbt_pkg::t_result tokens_due[$];     // predicted tokens, oldest first
    int               total_beats  = 0;
    int               beats_taken  = 0;
    int               fail_count   = 0;
    bit               beat_taken   = 1'b0;

    function automatic sbt_pkg::t_result tok(input logic [3:0] kind,
                                             input logic [2:0] sub,
                                             input logic [sbt_pkg::POS_BITS-1:0] off,
                                             input logic [sbt_pkg::POS_BITS-1:0] len,
                                             input logic [63:0] value);
        sbt_pkg::t_result r;
        r.kind   = kind;
        r.sub    = sub;
        r.offset = 32'(off);
        r.length = 32'(len);
        r.value  = value;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic sbt_pkg::t_result number_token(
            input logic [sbt_pkg::POS_BITS-1:0] run);
        return tok(sbt_pkg::KIND_NUM, sbt_pkg::SUB_NONE, lex_start, run, lex_acc);
    endfunction

    // Keyword match needs both the exact length and the packed prefix.
    function automatic sbt_pkg::t_result word_token(
            input logic [sbt_pkg::POS_BITS-1:0] run);
        if (run == 6 && lex_prefix == sbt_pkg::WORD_RETURN)
            return tok(sbt_pkg::KIND_KEYWORD, sbt_pkg::SUB_KW_RETURN, lex_start, run, '0);
        else if (run == 2 && lex_prefix == sbt_pkg::WORD_IF)
            return tok(sbt_pkg::KIND_KEYWORD, sbt_pkg::SUB_KW_IF, lex_start, run, '0);
        else if (run == 5 && lex_prefix == sbt_pkg::WORD_WHILE)
            return tok(sbt_pkg::KIND_KEYWORD, sbt_pkg::SUB_KW_WHILE, lex_start, run, '0);
        return tok(sbt_pkg::KIND_IDENT, sbt_pkg::SUB_NONE, lex_start, run, '0);
    endfunction

    // Decimal accumulate, sticking at the 64-bit max once it would overflow.
    task automatic add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - "0");
        if (!lex_sat) begin
            if (lex_acc > (U64_MAX - d) / RADIX) begin
                lex_acc = U64_MAX;
                lex_sat = 1'b1;
            end else begin
                lex_acc = lex_acc * RADIX + d;
            end
        end
    endtask

    // Predicts the tokens caused by one accepted beat.
    task automatic lex_byte(input logic mode, input logic [7:0] c);
        sbt_pkg::t_result             made[$];
        logic [sbt_pkg::POS_BITS-1:0] run;
        logic                         digit, alpha, space, rescan;
        run    = lex_pos - lex_start;
        digit  = (c >= "0") && (c <= "9");
        alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        space  = (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
        rescan = 1'b1;
        if (mode) begin
            // end of source flushes a pending run, then everything restarts
            if (lex_state == LX_NUM)
                made.push_back(number_token(run));
            else if (lex_state == LX_WORD)
                made.push_back(word_token(run));
            made.push_back(tok(sbt_pkg::KIND_END, sbt_pkg::SUB_NONE, lex_pos, '0, '0));
            lex_state  = LX_IDLE;
            lex_pos    = '0;
            lex_start  = '0;
            lex_acc    = '0;
            lex_sat    = 1'b0;
            lex_prefix = '0;
        end else begin
            case (lex_state)
                LX_NUM: begin
                    if (digit) begin
                        add_digit(c);
                        rescan = 1'b0;
                    end else if (alpha) begin
                        // letter glued to a number: error only, no number token
                        made.push_back(tok(sbt_pkg::KIND_ERROR,
                                           sbt_pkg::SUB_ERR_UNSEPARATED,
                                           lex_pos, '0, '0));
                        lex_state = LX_FAIL;
                        rescan    = 1'b0;
                    end else begin
                        made.push_back(number_token(run));
                        lex_state = LX_IDLE;
                    end
                end
                LX_WORD: begin
                    if (alpha || digit || c == "_") begin
                        if (run < sbt_pkg::PREFIX_BYTES)
                            lex_prefix = {lex_prefix[39:0], c};
                        rescan = 1'b0;
                    end else begin
                        made.push_back(word_token(run));
                        lex_state = LX_IDLE;
                    end
                end
                LX_FAIL: rescan = 1'b0;
                default: ;
            endcase
            if (rescan) begin
                if (space) begin
                end else if (digit) begin
                    lex_state = LX_NUM;
                    lex_start = lex_pos;
                    lex_acc   = '0;
                    lex_sat   = 1'b0;
                    add_digit(c);
                end else if (alpha || c == "_") begin
                    lex_state  = LX_WORD;
                    lex_start  = lex_pos;
                    lex_prefix = {40'b0, c};
                end else begin
                    case (c)
                        ";": made.push_back(tok(sbt_pkg::KIND_SEMI, sbt_pkg::SUB_NONE,
                                                lex_pos, 1, '0));
                        ":": made.push_back(tok(sbt_pkg::KIND_COLON, sbt_pkg::SUB_NONE,
                                                lex_pos, 1, '0));
                        "=": made.push_back(tok(sbt_pkg::KIND_ASSIGN, sbt_pkg::SUB_NONE,
                                                lex_pos, 1, '0));
                        "{": made.push_back(tok(sbt_pkg::KIND_LCURLY, sbt_pkg::SUB_NONE,
                                                lex_pos, 1, '0));
                        "}": made.push_back(tok(sbt_pkg::KIND_RCURLY, sbt_pkg::SUB_NONE,
                                                lex_pos, 1, '0));
                        "+": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_PLUS,
                                                lex_pos, 1, '0));
                        "-": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_MINUS,
                                                lex_pos, 1, '0));
                        "*": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_STAR,
                                                lex_pos, 1, '0));
                        "/": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_SLASH,
                                                lex_pos, 1, '0));
                        "<": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_LESS,
                                                lex_pos, 1, '0));
                        ">": made.push_back(tok(sbt_pkg::KIND_OP, sbt_pkg::SUB_GREATER,
                                                lex_pos, 1, '0));
                        default: begin
                            made.push_back(tok(sbt_pkg::KIND_ERROR,
                                               sbt_pkg::SUB_ERR_UNKNOWN,
                                               lex_pos, '0, '0));
                            lex_state = LX_FAIL;
                        end
                    endcase
                end
            end
            lex_pos = lex_pos + 1'b1;
        end
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            tokens_due.push_back(made[i]);
    endtask

    task automatic log_fail(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    string word_pool [0:13] = '{"return", "if", "while", "retur", "returns", "whil",
                                "whiles", "i", "iff", "If", "RETURN", "while_",
                                "if1", "returnx"};
    string num_pool [0:5] = '{"18446744073709551615", "18446744073709551616",
                              "18446744073709551619", "99999999999999999999",
                              "0", "00000000000000000000000001"};
    string odd_bytes = "!\"#$%&'(),.?@[\\]^|~";
    string punct_set = ";:={}+-*/<>";

    task automatic put_byte(input logic [7:0] c);
        source_beats.push_back('{mode: 1'b0, ch: c});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_end(input logic [7:0] c);
        source_beats.push_back('{mode: 1'b1, ch: c});
    endtask

    task automatic put_space();
        put_byte(($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            put_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    // Random token runs; prev_run remembers whether a number (1) or word (2)
    // is still open so that most neighbors get a separator.
    task automatic build_random();
        int         pick, prev_run;
        logic [7:0] first;
        prev_run = 0;
        while (source_beats.size() < TARGET_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                if (prev_run != 0 && $urandom_range(0, 4) != 0)
                    put_space();
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    put_digits($urandom_range(1, 4));
                else if (pick < 85)
                    put_digits($urandom_range(15, 22));
                else
                    put_text(num_pool[$urandom_range(0, 5)]);
                prev_run = 1;
            end else if (pick < 50) begin
                first = ($urandom_range(0, 3) == 0) ? 8'h5F : rand_letter();
                if (prev_run != 0 &&
                    ($urandom_range(0, 4) != 0 || (prev_run == 1 && first != "_")))
                    put_space();
                if ($urandom_range(0, 1)) begin
                    put_text(word_pool[$urandom_range(0, 13)]);
                end else begin
                    put_byte(first);
                    repeat ($urandom_range(0, 7)) begin
                        case ($urandom_range(0, 3))
                            0:       put_byte(8'("0" + $urandom_range(0, 9)));
                            1:       put_byte(8'h5F);
                            default: put_byte(rand_letter());
                        endcase
                    end
                end
                prev_run = 2;
            end else if (pick < 70) begin
                put_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
                prev_run = 0;
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 3)) put_space();
                prev_run = 0;
            end else if (pick < 90) begin
                put_end(8'($urandom_range(0, 255)));
                prev_run = 0;
            end else begin
                // error runs: unknown byte, or digits glued to a letter
                if (pick < 94) begin
                    case ($urandom_range(0, 3))
                        0: put_byte(8'($urandom_range(128, 255)));
                        1: put_byte(($urandom_range(0, 1)) ? 8'($urandom_range(0, 8))
                                                           : 8'($urandom_range(14, 31)));
                        2: put_byte(8'h7F);
                        default: put_byte(odd_bytes[$urandom_range(0, odd_bytes.len() - 1)]);
                    endcase
                end else begin
                    if (prev_run != 0)
                        put_space();
                    put_digits($urandom_range(1, 3));
                    put_byte(rand_letter());
                end
                // failed state swallows bytes until the end beat
                repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
                put_end(8'($urandom_range(0, 255)));
                prev_run = 0;
            end
        end
        put_end(8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of beats separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !beat_taken) begin
            // beat still offered, hold it
        end else begin
            beat_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (source_beats.size() > 0) begin
                i_valid <= 1'b1;
                i_mode  <= source_beats[0].mode;
                i_ch    <= source_beats[0].ch;
                source_beats.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(10, 30);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall pattern: a random style, redrawn after a random count of cycles
    // ------------------------------------------------------------------------
    int ready_style = 0;
    int ready_left  = 0;
    int ready_phase = 0;
    int hold_left   = 0;
    bit hold_val    = 1'b1;

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_left  = $urandom_range(100, 400);
        end
        ready_left--;
        ready_phase++;
        case (ready_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (ready_phase % 5) != 0;
            default: begin
                if (hold_left == 0) begin
                    hold_val  = !hold_val;
                    hold_left = $urandom_range(1, 12);
                end
                hold_left--;
                i_ready <= hold_val;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input beats, check on output beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        sbt_pkg::t_result got, want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                lex_byte(i_mode, i_ch);
                beat_taken = 1'b1;
                beats_taken++;
            end
            if (o_valid && i_ready) begin
                got = '{kind: o_token_kind, sub: o_sub_code, offset: o_token_offset,
                        length: o_token_length, value: o_number_value,
                        last: o_final_res};
                if (tokens_due.size() == 0) begin
                    log_fail($sformatf("unexpected token kind=%0d sub=%0d off=%0d len=%0d",
                                       got.kind, got.sub, got.offset, got.length));
                end else begin
                    want = tokens_due.pop_front();
                    if (got.kind !== want.kind || got.sub !== want.sub ||
                        got.offset !== want.offset || got.length !== want.length ||
                        got.value !== want.value || got.last !== want.last)
                        log_fail($sformatf({"token mismatch exp kind=%0d sub=%0d off=%0d ",
                                            "len=%0d val=%h last=%0d | got kind=%0d ",
                                            "sub=%0d off=%0d len=%0d val=%h last=%0d"},
                                           want.kind, want.sub, want.offset, want.length,
                                           want.value, want.last, got.kind, got.sub,
                                           got.offset, got.length, got.value, got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed text, random text, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        // keywords and every punctuator back to back
        put_text("return{if}while;:=+-*/<>");
        put_end(8'h00);
        // number ended by underscore opens a word
        put_text("12_x");
        put_end(8'hFF);
        // digits glued to a letter, then an unknown high byte
        put_text("7a");
        put_end(8'h00);
        put_byte(8'hFF);
        put_end(8'hFF);
        build_random();
        total_beats = source_beats.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats) @(negedge i_clk);
        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (tokens_due.size() != 0)
            log_fail($sformatf("%0d tokens never arrived", tokens_due.size()));
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
